// File: rtl/ast_pkg.sv
// shared types, constants and saturation helpers for the agent steering core
// no dependencies; imported by ast_iter_unit and agent_steering_step_core
package ast_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned STOP_UNITS = 10;
  localparam int unsigned Z_TOP_UNITS = 200;

  typedef enum logic [2:0] {
    FN_UPDATE  = 3'd0,
    FN_BOUNCE  = 3'd1,
    FN_SEEK    = 3'd2,
    FN_FLEE    = 3'd3,
    FN_ARRIVE  = 3'd4,
    FN_PURSUE  = 3'd5,
    FN_SET_POS = 3'd6,
    FN_SET_VEL = 3'd7
  } func_e;

  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] num;
    logic [31:0] den;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } iter_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] units(input logic [14:0] u);
    logic [63:0] w;
    w = 64'(u) << FRAC_BITS;
    return sat32(signed'(w));
  endfunction

endpackage

// File: rtl/ast_iter_unit.sv
// shared iterative unit: one-bit-per-cycle unsigned divide and integer square root
// one 64-bit subtractor serves both; uses ast_pkg
module ast_iter_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ast_pkg::iter_req_t req_i,
  output ast_pkg::iter_rsp_t rsp_o
);
  import ast_pkg::*;

  logic        busy_q, sqrt_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] x_q, r_q, bit_q;
  logic [31:0] den_q;
  logic [32:0] rem_sh;
  logic [63:0] opa, opb;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {r_q[31:0], x_q[63]};
    opa    = sqrt_q ? x_q : {31'b0, rem_sh};
    opb    = sqrt_q ? (r_q + bit_q) : {32'b0, den_q};
    diff   = {1'b0, opa} - {1'b0, opb};
    ge     = !diff[64];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        sqrt_q <= req_i.is_sqrt;
        cnt_q  <= req_i.is_sqrt ? 6'd31 : 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.num;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
      den_q <= req_i.den;
    end else if (busy_q) begin
      if (sqrt_q) begin
        if (ge) begin
          x_q <= diff[63:0];
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        x_q <= {x_q[62:0], ge};
        r_q <= ge ? {32'b0, diff[31:0]} : {32'b0, rem_sh[31:0]};
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = sqrt_q ? r_q : x_q;

endmodule

// File: rtl/agent_steering_step_core.sv
// Steering core for one agent: holds position, velocity and accumulated force in Q16.16
// and runs one command per transaction on a shared multiplier and divide/sqrt unit.
// Set and bounce commands do not use the shared units; seek, flee, arrive, pursue and update
// may use the square root and the up to six per-axis divisions of the shared iterative unit,
// and the core accepts no new command until the current one has finished.
// Depends on ast_pkg and ast_iter_unit.
module agent_steering_step_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // target_x, target_y, target_z, target_vel_x, target_vel_y, target_vel_z
  input  logic [191:0] s_axis_tdata,
  // func
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic [191:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ast_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_OFS  = 5'd1;
  localparam logic [4:0] S_SQM  = 5'd2;
  localparam logic [4:0] S_SQA  = 5'd3;
  localparam logic [4:0] S_LLIM = 5'd4;
  localparam logic [4:0] S_LCMP = 5'd5;
  localparam logic [4:0] S_SQRT = 5'd6;
  localparam logic [4:0] S_SQW  = 5'd7;
  localparam logic [4:0] S_VMUL = 5'd8;
  localparam logic [4:0] S_VDIV = 5'd9;
  localparam logic [4:0] S_VDW  = 5'd10;
  localparam logic [4:0] S_VAPP = 5'd11;
  localparam logic [4:0] S_ADDV = 5'd12;
  localparam logic [4:0] S_ADDP = 5'd13;
  localparam logic [4:0] S_BNC  = 5'd14;
  localparam logic [4:0] S_OUT  = 5'd15;

  localparam logic [1:0] VS_D   = 2'd0;
  localparam logic [1:0] VS_FRC = 2'd1;
  localparam logic [1:0] VS_VEL = 2'd2;

  localparam logic [2:0] REG_MAX_SPEED = 3'd0;
  localparam logic [2:0] REG_MAX_STEER = 3'd1;
  localparam logic [2:0] REG_RADIUS    = 3'd2;
  localparam logic [2:0] REG_WIDTH     = 3'd3;
  localparam logic [2:0] REG_HEIGHT    = 3'd4;

  localparam logic [31:0] STOP_DIST = 32'(STOP_UNITS << FRAC_BITS);

  logic [4:0]  state_q;
  func_e       op_q;
  logic        phase_q, dneg_q, mv_q;
  logic [1:0]  k_q, vsel_q;
  logic signed [31:0] t_q [3];
  logic signed [31:0] tv_q [3];
  logic signed [31:0] d_q [3];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] frc_q [3];
  logic [63:0] acc_q;
  logic signed [63:0] prod_q;
  logic [31:0] dist_q;
  logic signed [31:0] q_q;
  logic [191:0] out_q;

  logic [24:0] ms_q, st_q;
  logic [30:0] rad_q;
  logic [14:0] aw_q, ah_q;

  logic signed [31:0] sqv;
  logic [24:0] lim_c;
  logic [31:0] div_c;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic [63:0] mag_c;
  logic signed [63:0] qs_c, tt_c;
  logic signed [31:0] lo_c [3];
  logic signed [31:0] hi_c [3];
  iter_req_t ireq;
  iter_rsp_t irsp;
  logic in_acc, cfg_wr;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_wr = psel && penable && pwrite;
  assign s_axis_tready = (state_q == S_IDLE);
  assign pready = 1'b1;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata = out_q;

  always_comb begin
    unique case (paddr[4:2])
      REG_MAX_SPEED: prdata = 32'(ms_q);
      REG_MAX_STEER: prdata = 32'(st_q);
      REG_RADIUS:    prdata = 32'(rad_q);
      REG_WIDTH:     prdata = 32'(aw_q);
      REG_HEIGHT:    prdata = 32'(ah_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q  <= 25'(30 << FRAC_BITS);
      st_q  <= 25'(2 << FRAC_BITS);
      rad_q <= 31'(140 << FRAC_BITS);
      aw_q  <= 15'd1024;
      ah_q  <= 15'd768;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MAX_SPEED: ms_q  <= pwdata[24:0];
        REG_MAX_STEER: st_q  <= pwdata[24:0];
        REG_RADIUS:    rad_q <= pwdata[30:0];
        REG_WIDTH:     aw_q  <= pwdata[14:0];
        REG_HEIGHT:    ah_q  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (vsel_q)
      VS_FRC:  sqv = frc_q[k_q];
      VS_VEL:  sqv = vel_q[k_q];
      default: sqv = d_q[k_q];
    endcase
    lim_c = (vsel_q == VS_VEL) ? ms_q : st_q;
    if (op_q == FN_UPDATE) div_c = dist_q;
    else if (op_q == FN_PURSUE && !phase_q) div_c = 32'(ms_q);
    else if (op_q == FN_ARRIVE && dist_q <= 32'(rad_q)) div_c = 32'(rad_q);
    else div_c = dist_q;

    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQM: begin
        mul_a = 33'(sqv);
        mul_b = 33'(sqv);
      end
      S_LLIM: begin
        mul_a = signed'(33'(lim_c));
        mul_b = signed'(33'(lim_c));
      end
      S_VMUL: begin
        if (op_q == FN_PURSUE && !phase_q) begin
          mul_a = 33'(tv_q[k_q]);
          mul_b = signed'({1'b0, dist_q});
        end else if (op_q == FN_UPDATE) begin
          mul_a = 33'(sqv);
          mul_b = signed'(33'(lim_c));
        end else begin
          mul_a = 33'(d_q[k_q]);
          mul_b = signed'(33'(ms_q));
        end
      end
      default: ;
    endcase
    mul_full = mul_a * mul_b;

    mag_c = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
    qs_c  = dneg_q ? -signed'(irsp.value) : signed'(irsp.value);
    tt_c  = 64'(q_q) - 64'(vel_q[k_q]);

    ireq.start   = (state_q == S_SQRT) || (state_q == S_VDIV && div_c != '0);
    ireq.is_sqrt = (state_q == S_SQRT);
    ireq.num     = (state_q == S_SQRT) ? acc_q : mag_c;
    ireq.den     = div_c;

    lo_c[0] = '0;
    hi_c[0] = units(aw_q);
    lo_c[1] = '0;
    hi_c[1] = units(ah_q);
    lo_c[2] = -units(ah_q);
    hi_c[2] = units(15'(Z_TOP_UNITS));
  end

  ast_iter_unit u_iter (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ireq),
    .rsp_o (irsp)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= FN_UPDATE;
      phase_q <= 1'b0;
      dneg_q  <= 1'b0;
      mv_q    <= 1'b0;
      k_q     <= '0;
      vsel_q  <= VS_D;
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
        frc_q[i] <= '0;
      end
      pos_q[0] <= 32'(300 << FRAC_BITS);
      pos_q[1] <= 32'(300 << FRAC_BITS);
      pos_q[2] <= '0;
    end else begin
      if (state_q == S_OUT && (!mv_q || m_axis_tready)) mv_q <= 1'b1;
      else if (mv_q && m_axis_tready) mv_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q    <= func_e'(s_axis_tuser);
            phase_q <= 1'b0;
            k_q     <= '0;
            acc_q   <= '0;
            vsel_q  <= VS_FRC;
            for (int i = 0; i < 3; i++) begin
              t_q[i]  <= s_axis_tdata[32*i +: 32];
              tv_q[i] <= s_axis_tdata[96 + 32*i +: 32];
            end
            unique case (func_e'(s_axis_tuser))
              FN_UPDATE: state_q <= S_SQM;
              FN_BOUNCE: state_q <= S_BNC;
              FN_SET_POS: begin
                for (int i = 0; i < 3; i++) pos_q[i] <= s_axis_tdata[32*i +: 32];
                state_q <= S_OUT;
              end
              FN_SET_VEL: begin
                for (int i = 0; i < 3; i++) vel_q[i] <= s_axis_tdata[32*i +: 32];
                state_q <= S_OUT;
              end
              default: state_q <= S_OFS;
            endcase
          end
        end
        S_OFS: begin
          for (int i = 0; i < 3; i++) d_q[i] <= sat32(64'(t_q[i]) - 64'(pos_q[i]));
          vsel_q  <= VS_D;
          acc_q   <= '0;
          k_q     <= '0;
          state_q <= S_SQM;
        end
        S_SQM: state_q <= S_SQA;
        S_SQA: begin
          acc_q <= acc_q + 64'(prod_q);
          if (k_q == 2'd2) begin
            k_q     <= '0;
            state_q <= (op_q == FN_UPDATE) ? S_LLIM : S_SQRT;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_SQM;
          end
        end
        S_LLIM: state_q <= S_LCMP;
        S_LCMP: begin
          if (acc_q > 64'(prod_q)) state_q <= S_SQRT;
          else state_q <= (vsel_q == VS_FRC) ? S_ADDV : S_ADDP;
        end
        S_SQRT: state_q <= S_SQW;
        S_SQW: begin
          if (irsp.done) begin
            dist_q <= irsp.value[31:0];
            k_q    <= '0;
            if (op_q == FN_ARRIVE && irsp.value[31:0] <= STOP_DIST) begin
              for (int i = 0; i < 3; i++) begin
                frc_q[i] <= '0;
                vel_q[i] <= '0;
              end
              state_q <= S_OUT;
            end else begin
              state_q <= S_VMUL;
            end
          end
        end
        S_VMUL: state_q <= S_VDIV;
        S_VDIV: begin
          dneg_q <= prod_q[63];
          if (div_c == '0) begin
            q_q     <= '0;
            state_q <= S_VAPP;
          end else begin
            state_q <= S_VDW;
          end
        end
        S_VDW: begin
          if (irsp.done) begin
            q_q     <= sat32(qs_c);
            state_q <= S_VAPP;
          end
        end
        S_VAPP: begin
          if (op_q == FN_UPDATE) begin
            if (vsel_q == VS_VEL) vel_q[k_q] <= q_q;
            else frc_q[k_q] <= q_q;
          end else if (op_q == FN_PURSUE && !phase_q) begin
            t_q[k_q] <= sat32(64'(t_q[k_q]) + 64'(q_q));
          end else if (op_q == FN_FLEE) begin
            frc_q[k_q] <= sat32(64'(frc_q[k_q]) - tt_c);
          end else begin
            frc_q[k_q] <= sat32(64'(frc_q[k_q]) + tt_c);
          end
          if (k_q == 2'd2) begin
            k_q <= '0;
            if (op_q == FN_UPDATE) begin
              state_q <= (vsel_q == VS_FRC) ? S_ADDV : S_ADDP;
            end else if (op_q == FN_PURSUE && !phase_q) begin
              phase_q <= 1'b1;
              state_q <= S_OFS;
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_VMUL;
          end
        end
        S_ADDV: begin
          for (int i = 0; i < 3; i++) vel_q[i] <= sat32(64'(vel_q[i]) + 64'(frc_q[i]));
          vsel_q  <= VS_VEL;
          acc_q   <= '0;
          k_q     <= '0;
          state_q <= S_SQM;
        end
        S_ADDP: begin
          for (int i = 0; i < 3; i++) pos_q[i] <= sat32(64'(pos_q[i]) + 64'(vel_q[i]));
          state_q <= S_OUT;
        end
        S_BNC: begin
          for (int i = 0; i < 3; i++) begin
            if (pos_q[i] > hi_c[i]) begin
              pos_q[i] <= hi_c[i];
              vel_q[i] <= sat32(-64'(vel_q[i]));
            end else if (pos_q[i] < lo_c[i]) begin
              pos_q[i] <= lo_c[i];
              vel_q[i] <= sat32(-64'(vel_q[i]));
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!mv_q || m_axis_tready) begin
            out_q <= {vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("core took a second command while busy");

  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irsp.done |-> (state_q == S_SQW || state_q == S_VDW))
    else $error("iterative unit finished outside a wait state");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_OUT)
    else $error("result raised without finishing a command");

endmodule
